// ===== rtl/per_port_packet_size_stats_assert.svh =====
// Assertion macros shared by the checker of the packet statistics block.
// Macros expect aclk in the using scope; all but PPS_ASSERT_RESET use aresetn.
`ifndef PER_PORT_PACKET_SIZE_STATS_ASSERT_SVH
`define PER_PORT_PACKET_SIZE_STATS_ASSERT_SVH

// Implication in the same cycle, disabled during reset.
`define PPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pps assertion failed");

// Implication into the next cycle, disabled during reset.
`define PPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pps assertion failed");

// Implication into the next cycle that is also checked while reset is asserted.
`define PPS_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pps assertion failed");

`endif

// ===== rtl/pps_pkg.sv =====
// Types, constants and the size classifier of the packet statistics block.
// Used by every RTL file of the block but pps_ram and the macros header; depends on nothing.
package pps_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int CLASS_W     = $clog2(NUM_CLASSES);
    localparam int PORT_FIELD_W = 32;
    localparam int LEN_W       = 20;
    localparam int COUNT_W     = 64;

    localparam logic [LEN_W-1:0] CLASS_BOUND_0 = LEN_W'(64);
    localparam logic [LEN_W-1:0] CLASS_BOUND_1 = LEN_W'(128);
    localparam logic [LEN_W-1:0] CLASS_BOUND_2 = LEN_W'(256);
    localparam logic [LEN_W-1:0] CLASS_BOUND_3 = LEN_W'(512);
    localparam logic [LEN_W-1:0] CLASS_BOUND_4 = LEN_W'(1024);
    localparam logic [LEN_W-1:0] CLASS_BOUND_5 = LEN_W'(1500);
    localparam logic [LEN_W-1:0] CLASS_BOUND_6 = LEN_W'(9000);

    typedef struct packed {
        logic                    kind;
        logic [PORT_FIELD_W-1:0] port;
        logic [LEN_W-1:0]        packet_length;
    } in_word_t;

    typedef struct packed {
        logic               counted;
        logic [CLASS_W-1:0] size_class;
        logic [COUNT_W-1:0] packet_total;
        logic [COUNT_W-1:0] byte_total;
        logic [COUNT_W-1:0] class_total;
    } out_word_t;

    typedef struct packed {
        logic                    counted;
        logic [CLASS_W-1:0]      size_class;
        logic                    kind;
        logic [PORT_FIELD_W-1:0] port;
        logic [LEN_W-1:0]        packet_length;
    } job_t;

    typedef struct packed {
        logic clear_done;
        logic pop;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_FETCH,
        ST_WAIT
    } back_state_t;

    function automatic logic [CLASS_W-1:0] size_class_of(input logic [LEN_W-1:0] len);
        logic [CLASS_W-1:0] cls;
        if (len <= CLASS_BOUND_0) begin
            cls = CLASS_W'(0);
        end else if (len <= CLASS_BOUND_1) begin
            cls = CLASS_W'(1);
        end else if (len <= CLASS_BOUND_2) begin
            cls = CLASS_W'(2);
        end else if (len <= CLASS_BOUND_3) begin
            cls = CLASS_W'(3);
        end else if (len <= CLASS_BOUND_4) begin
            cls = CLASS_W'(4);
        end else if (len <= CLASS_BOUND_5) begin
            cls = CLASS_W'(5);
        end else if (len <= CLASS_BOUND_6) begin
            cls = CLASS_W'(6);
        end else begin
            cls = CLASS_W'(7);
        end
        return cls;
    endfunction

endpackage

// ===== rtl/per_port_packet_size_stats.sv =====
// Per-port packet, byte and size-class counters; top level of the block.
// Path: a word goes from the queue through the job register to the result register.
// No word leaves the queue during the last one's read-modify-write or a result stall.
// Reset: synchronous and active low; a clearing pass that zeroes every entry of the
// counter tables follows, with s_ready low until it ends.
module per_port_packet_size_stats #(
    parameter int NUM_PORTS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pps_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output pps_pkg::out_word_t m_word
);

    logic                  job_valid;
    pps_pkg::job_t         job;
    pps_pkg::back_status_t back_status;

    pps_front #(.NUM_PORTS(NUM_PORTS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .back_status (back_status),
        .job_valid   (job_valid),
        .job         (job)
    );

    pps_back #(.NUM_PORTS(NUM_PORTS)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job         (job),
        .back_status (back_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

endmodule

// ===== rtl/pps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Stands alone; used for the counter tables of the statistics block.
module pps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pps_front.sv =====
// Input side: classifies each packet word and holds it in a short queue.
// Depends on pps_pkg for the word types and the size classifier.
module pps_front #(
    parameter int NUM_PORTS = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pps_pkg::in_word_t    s_word,
    input  pps_pkg::back_status_t back_status,
    output logic                 job_valid,
    output pps_pkg::job_t        job
);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    pps_pkg::job_t     queue_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    pps_pkg::job_t     new_job;
    logic              push;
    logic              pop;

    always_comb begin
        new_job.counted       = (s_word.port < pps_pkg::PORT_FIELD_W'(NUM_PORTS));
        new_job.size_class    = pps_pkg::size_class_of(s_word.packet_length);
        new_job.kind          = s_word.kind;
        new_job.port          = s_word.port;
        new_job.packet_length = s_word.packet_length;
    end

    assign s_ready   = (count_reg != (Q_PTR_W+1)'(Q_DEPTH)) && back_status.clear_done;
    assign push      = s_valid && s_ready;
    assign pop       = back_status.pop;
    assign job_valid = (count_reg != '0);
    assign job       = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (Q_PTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

// ===== rtl/pps_back.sv =====
// Counter side: clears the tables after reset, then counts each queued in-range word; every word gives a result.
// Depends on pps_pkg and on pps_ram for the packet/byte and size-class tables.
module pps_back #(
    parameter int NUM_PORTS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  job_valid,
    input  pps_pkg::job_t         job,
    output pps_pkg::back_status_t back_status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pps_pkg::out_word_t    m_word
);

    localparam int PORT_W     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam int ENTRY_W    = PORT_W + 1;
    localparam int CLS_ADDR_W = ENTRY_W + pps_pkg::CLASS_W;
    localparam int CW         = pps_pkg::COUNT_W;

    pps_pkg::back_state_t state_reg, state_next;
    logic [CLS_ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    pps_pkg::job_t         job_reg, job_next;
    logic                  m_valid_reg, m_valid_next;
    pps_pkg::out_word_t    m_word_reg, m_word_next;

    logic                  take;
    logic                  tot_wr_en, cls_wr_en;
    logic [ENTRY_W-1:0]    tot_wr_addr, tot_rd_addr;
    logic [CLS_ADDR_W-1:0] cls_wr_addr, cls_rd_addr;
    logic [2*CW-1:0]       tot_wr_data, tot_rd_data;
    logic [CW-1:0]         cls_wr_data, cls_rd_data;
    logic [CW-1:0]         pkt_sum, byte_sum, cls_sum;

    pps_ram #(.WIDTH(2*CW), .DEPTH(2**ENTRY_W)) u_tot_ram (
        .aclk    (aclk),
        .wr_en   (tot_wr_en),
        .wr_addr (tot_wr_addr),
        .wr_data (tot_wr_data),
        .rd_addr (tot_rd_addr),
        .rd_data (tot_rd_data)
    );

    pps_ram #(.WIDTH(CW), .DEPTH(2**CLS_ADDR_W)) u_cls_ram (
        .aclk    (aclk),
        .wr_en   (cls_wr_en),
        .wr_addr (cls_wr_addr),
        .wr_data (cls_wr_data),
        .rd_addr (cls_rd_addr),
        .rd_data (cls_rd_data)
    );

    assign take     = job_valid && (!m_valid_reg || m_ready);
    assign pkt_sum  = tot_rd_data[2*CW-1:CW] + CW'(1);
    assign byte_sum = tot_rd_data[CW-1:0] + CW'(job_reg.packet_length);
    assign cls_sum  = cls_rd_data + CW'(1);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::ST_CLEAR: begin
                if (clr_addr_reg == '1) begin
                    state_next = pps_pkg::ST_FETCH;
                end
            end
            pps_pkg::ST_FETCH: begin
                if (take) begin
                    state_next = pps_pkg::ST_WAIT;
                end
            end
            pps_pkg::ST_WAIT: begin
                state_next = pps_pkg::ST_FETCH;
            end
            default: begin
                state_next = pps_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        back_status.clear_done = 1'b1;
        back_status.pop        = 1'b0;
        clr_addr_next          = clr_addr_reg;
        job_next               = job_reg;
        m_valid_next           = m_valid_reg && !m_ready;
        m_word_next            = m_word_reg;
        tot_rd_addr            = {job.port[PORT_W-1:0], job.kind};
        cls_rd_addr            = {job.port[PORT_W-1:0], job.kind, job.size_class};
        tot_wr_en              = 1'b0;
        cls_wr_en              = 1'b0;
        tot_wr_addr            = {job_reg.port[PORT_W-1:0], job_reg.kind};
        cls_wr_addr            = {job_reg.port[PORT_W-1:0], job_reg.kind, job_reg.size_class};
        tot_wr_data            = {pkt_sum, byte_sum};
        cls_wr_data            = cls_sum;
        case (state_reg)
            pps_pkg::ST_CLEAR: begin
                back_status.clear_done = 1'b0;
                clr_addr_next          = clr_addr_reg + CLS_ADDR_W'(1);
                tot_wr_en              = 1'b1;
                cls_wr_en              = 1'b1;
                tot_wr_addr            = clr_addr_reg[ENTRY_W-1:0];
                cls_wr_addr            = clr_addr_reg;
                tot_wr_data            = '0;
                cls_wr_data            = '0;
            end
            pps_pkg::ST_FETCH: begin
                back_status.pop = take;
                if (take) begin
                    job_next = job;
                end
            end
            pps_pkg::ST_WAIT: begin
                tot_wr_en               = job_reg.counted;
                cls_wr_en               = job_reg.counted;
                m_valid_next            = 1'b1;
                m_word_next.counted     = job_reg.counted;
                m_word_next.size_class  = job_reg.size_class;
                m_word_next.packet_total = job_reg.counted ? pkt_sum : '0;
                m_word_next.byte_total  = job_reg.counted ? byte_sum : '0;
                m_word_next.class_total = job_reg.counted ? cls_sum : '0;
            end
            default: begin
                back_status.clear_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pps_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_word_reg <= m_word_next;
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== rtl/pps_checker.sv =====
// Port-level checks of the packet statistics block, bound to its top level.
// Depends on pps_pkg and on the assertion macros header.
`include "per_port_packet_size_stats_assert.svh"

module pps_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input pps_pkg::in_word_t  s_word,
    input logic               m_valid,
    input logic               m_ready,
    input pps_pkg::out_word_t m_word
);

    logic totals_zero;

    assign totals_zero = (m_word.packet_total == '0) && (m_word.byte_total == '0)
                         && (m_word.class_total == '0);

    // A stalled result holds its word.
    `PPS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word))

    // A word for a port outside the table carries zero totals.
    `PPS_ASSERT_SAME(a_uncounted_zero, m_valid && !m_word.counted, totals_zero)

    // Reset starts the clearing pass with no word taken and no result shown.
    `PPS_ASSERT_RESET(a_reset_quiet, !aresetn, !s_ready && !m_valid)

endmodule

bind per_port_packet_size_stats pps_checker u_pps_checker (.*);
